// ===== src/thumb_peephole_rewriter_core_assert.svh =====
// assertion macros used by the checker file
`ifndef THUMB_PEEPHOLE_REWRITER_CORE_ASSERT_SVH
`define THUMB_PEEPHOLE_REWRITER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TPR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpr check failed");

// antecedent implies consequent in the next cycle
`define TPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpr check failed");

`endif

// ===== src/tpr_pkg.sv =====
// ----------------------------------------------------------------------------
// tpr_pkg
// Types, sizes and instruction words of the Thumb peephole rewriter.
// ----------------------------------------------------------------------------
package tpr_pkg;

  localparam int STORE_DEPTH    = 1024;
  localparam int PATTERN_LENGTH = 4;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int CNT_W          = $clog2(STORE_DEPTH + 1);
  localparam int HW_W           = 16;
  localparam int IDX_W          = 10;
  localparam int LEN_W          = 11;

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  localparam logic [HW_W-1:0] W_MOV_R0_R7 = 16'h4638;
  localparam logic [HW_W-1:0] W_PUSH_R0   = 16'hb401;
  localparam logic [HW_W-1:0] W_MOVS_R0   = 16'h2000;
  localparam logic [HW_W-1:0] W_POP_R3    = 16'hbc08;
  localparam logic [HW_W-1:0] IMM_MASK    = 16'hff00;
  localparam logic [HW_W-1:0] W_MOV_R3_R7 = 16'h463b;

  typedef struct packed {
    logic             mode;
    logic [HW_W-1:0]  halfword;
    logic [IDX_W-1:0] read_index;
  } in_t;

  typedef struct packed {
    logic [LEN_W-1:0] stream_length;
    logic [HW_W-1:0]  read_data;
    logic             rewrote;
    logic             error_flag;
  } out_t;

  typedef struct packed {
    logic first;
    logic second;
  } cap_t;

endpackage

// ===== src/tpr_store_ram.sv =====
// ----------------------------------------------------------------------------
// tpr_store_ram
// Simple dual-port code store, one write and one registered read port.
// ----------------------------------------------------------------------------
module tpr_store_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/tpr_matcher.sv =====
// ----------------------------------------------------------------------------
// tpr_matcher
// Collects the three words ahead of a pop and compares them with the pattern.
// ----------------------------------------------------------------------------
module tpr_matcher (
  input  logic                    clk,
  input  tpr_pkg::cap_t           cap,
  input  logic [tpr_pkg::HW_W-1:0] rd_data,
  output logic                    hit,
  output logic [7:0]              imm
);

  logic [tpr_pkg::HW_W-1:0] w0;
  logic [tpr_pkg::HW_W-1:0] w1;

  always_ff @(posedge clk) begin
    if (cap.first) begin
      w0 <= rd_data;
    end
    if (cap.second) begin
      w1 <= rd_data;
    end
  end

  assign hit = (w0 == tpr_pkg::W_MOV_R0_R7) && (w1 == tpr_pkg::W_PUSH_R0) &&
               ((rd_data & tpr_pkg::IMM_MASK) ==
                (tpr_pkg::W_MOVS_R0 & tpr_pkg::IMM_MASK));
  assign imm = rd_data[7:0];

endmodule

// ===== src/thumb_peephole_rewriter_core.sv =====
// ----------------------------------------------------------------------------
// thumb_peephole_rewriter_core
// Appends Thumb halfwords to a code store, folds the push/pop sequence and reads entries back.
// ----------------------------------------------------------------------------
// One input item gives exactly one result item. An item is a transfer on the
// in channel (in_valid high, in_stall low); a result is a transfer on the out
// channel. Mode append writes the halfword to the store; when it is a pop r3
// and three or more words precede it, the three earlier words are read back
// one per cycle through the single read port and, on a match, two rewritten
// words go out through the write port. Mode read returns one stored entry.
// Items are handled one at a time: a plain append goes straight to S_FIN;
// with a pattern check it passes S_RD1, S_RD2 and S_CMP first, and S_WR1
// too on a rewrite. A read passes S_RDW, or goes straight to S_FIN when the
// index is past the length. The next item is taken the cycle after the
// result is loaded. The result sits in an output register, so in_stall
// drops while a result still waits under out_stall; a result is only held
// back when the next one is ready and out_stall is high.
// Reset empties the store (length zero) and clears the output valid; the
// store contents are not cleared.
// ----------------------------------------------------------------------------
module thumb_peephole_rewriter_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  tpr_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_stall,
  output tpr_pkg::out_t out_item
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDW  = 3'd1;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_RD2  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_WR1  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]                       state;
  logic [tpr_pkg::CNT_W-1:0]        count;
  logic [tpr_pkg::ADDR_W-1:0]       base;
  logic [tpr_pkg::HW_W-1:0]         res_data;
  logic                             res_rw;
  logic                             res_err;

  logic                             accept;
  logic                             full;
  logic                             is_append;
  logic                             check;
  logic                             we;
  logic [tpr_pkg::ADDR_W-1:0]       waddr;
  logic [tpr_pkg::HW_W-1:0]         wdata;
  logic                             re;
  logic [tpr_pkg::ADDR_W-1:0]       raddr;
  logic [tpr_pkg::HW_W-1:0]         rd_data;
  tpr_pkg::cap_t                    cap;
  logic                             hit;
  logic [7:0]                       imm;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign full      = (count == tpr_pkg::CNT_W'(tpr_pkg::STORE_DEPTH));
  assign is_append = (in_item.mode == tpr_pkg::MODE_APPEND);
  assign check     = (in_item.halfword == tpr_pkg::W_POP_R3) &&
                     (count >= tpr_pkg::CNT_W'(tpr_pkg::PATTERN_LENGTH - 1));
  assign cap.first  = (state == S_RD1);
  assign cap.second = (state == S_RD2);

  always_comb begin
    we    = 1'b0;
    waddr = count[tpr_pkg::ADDR_W-1:0];
    wdata = in_item.halfword;
    re    = 1'b0;
    raddr = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && is_append && !full) begin
          we = 1'b1;
          if (check) begin
            re    = 1'b1;
            raddr = tpr_pkg::ADDR_W'(count - tpr_pkg::CNT_W'(tpr_pkg::PATTERN_LENGTH - 1));
          end
        end else if (accept && !is_append) begin
          re    = 1'b1;
          raddr = tpr_pkg::ADDR_W'(in_item.read_index);
        end
      end
      S_RD1: begin
        re    = 1'b1;
        raddr = base + tpr_pkg::ADDR_W'(1);
      end
      S_RD2: begin
        re    = 1'b1;
        raddr = base + tpr_pkg::ADDR_W'(2);
      end
      S_CMP: begin
        if (hit) begin
          we    = 1'b1;
          waddr = base;
          wdata = tpr_pkg::W_MOV_R3_R7;
        end
      end
      S_WR1: begin
        we    = 1'b1;
        waddr = base + tpr_pkg::ADDR_W'(1);
        wdata = tpr_pkg::W_MOVS_R0 | {8'h00, imm};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_data <= '0;
            res_rw   <= 1'b0;
            res_err  <= 1'b0;
            if (is_append) begin
              if (full) begin
                res_err <= 1'b1;
                state   <= S_FIN;
              end else begin
                count <= count + tpr_pkg::CNT_W'(1);
                if (check) begin
                  base  <= tpr_pkg::ADDR_W'(count -
                           tpr_pkg::CNT_W'(tpr_pkg::PATTERN_LENGTH - 1));
                  state <= S_RD1;
                end else begin
                  state <= S_FIN;
                end
              end
            end else if (tpr_pkg::CNT_W'(in_item.read_index) < count) begin
              state <= S_RDW;
            end else begin
              res_err <= 1'b1;
              state   <= S_FIN;
            end
          end
        end
        S_RDW: begin
          res_data <= rd_data;
          state    <= S_FIN;
        end
        S_RD1: state <= S_RD2;
        S_RD2: state <= S_CMP;
        S_CMP: begin
          state <= hit ? S_WR1 : S_FIN;
        end
        S_WR1: begin
          count  <= tpr_pkg::CNT_W'(base) + tpr_pkg::CNT_W'(2);
          res_rw <= 1'b1;
          state  <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_item.stream_length <= tpr_pkg::LEN_W'(count);
            out_item.read_data     <= res_data;
            out_item.rewrote       <= res_rw;
            out_item.error_flag    <= res_err;
            out_valid              <= 1'b1;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  tpr_store_ram #(
    .DEPTH (tpr_pkg::STORE_DEPTH),
    .WIDTH (tpr_pkg::HW_W)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_data)
  );

  tpr_matcher u_match (
    .clk     (clk),
    .cap     (cap),
    .rd_data (rd_data),
    .hit     (hit),
    .imm     (imm)
  );

endmodule

// ===== src/tpr_checker.sv =====
// ----------------------------------------------------------------------------
// tpr_checker
// Port-level checks of the Thumb peephole rewriter, bound to the top level.
// ----------------------------------------------------------------------------
`include "thumb_peephole_rewriter_core_assert.svh"

module tpr_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input tpr_pkg::in_t  in_item,
  input logic          out_valid,
  input logic          out_stall,
  input tpr_pkg::out_t out_item
);

  // stalled result holds
  `TPR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
  // one item at a time
  `TPR_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)
  `TPR_ASSERT_NOW(a_rw_not_err, out_valid, !(out_item.rewrote && out_item.error_flag))
  `TPR_ASSERT_NOW(a_rw_no_data, out_valid && out_item.rewrote, out_item.read_data == '0)
  `TPR_ASSERT_NOW(a_len_range, out_valid,
                  out_item.stream_length <= tpr_pkg::LEN_W'(tpr_pkg::STORE_DEPTH))

endmodule

bind thumb_peephole_rewriter_core tpr_checker u_tpr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
